/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tts_pkg.sv */
`default_nettype none

package tts_pkg;

  localparam int TTS_TABLE_SIZE = 1024;

  localparam int TTS_VOLUME_W = 12;
  localparam int TTS_COMPARE_W = 13;
  localparam int TTS_INC_W = 26;
  localparam int TTS_OFS_W = 12;
  localparam int TTS_SINE_W = 16;
  localparam int TTS_FRAC_W = 16;
  localparam int TTS_SAMPLE_SHIFT = 18;

  localparam int TTS_PADDR_W = 4;
  localparam int TTS_PDATA_W = 32;

  localparam logic [TTS_PADDR_W-1:0] TTS_ADDR_INC_A = 4'h0;
  localparam logic [TTS_PADDR_W-1:0] TTS_ADDR_INC_B = 4'h4;
  localparam logic [TTS_PADDR_W-1:0] TTS_ADDR_OFFSET = 4'h8;

  localparam logic [TTS_OFS_W-1:0] TTS_OFFSET_RESET = 12'd1200;

  localparam logic [63:0] TTS_ONE_Q62 = 64'h4000000000000000;
  localparam logic [63:0] TTS_HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam logic [63:0] TTS_SINE_AMP = 64'd32767;

  // restoring long division, elaboration use only
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // sin((pi/2)*r/t) in q2.62
  function automatic logic [63:0] quarter_sine(logic [63:0] t, logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] hq;
    logic [63:0] hr;
    logic [63:0] dv;
    if (r == 64'd0) begin
      return 64'd0;
    end
    if (r >= t) begin
      return TTS_ONE_Q62;
    end
    hq = udiv64(TTS_HALF_PI_Q62, t);
    hr = TTS_HALF_PI_Q62 - hq * t;
    x = hq * r + udiv64(hr * r, t);
    x2 = mul_q62(x, x);
    term = x;
    sum = x;
    for (int n = 1; n <= 12; n++) begin
      dv = 64'(2 * n) * 64'(2 * n + 1);
      term = udiv64(mul_q62(term, x2), dv);
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic logic signed [TTS_SINE_W-1:0] sine_entry(int unsigned t, int unsigned i);
    logic [63:0] k;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] mag;
    k = 64'(i) * 64'd4;
    q = udiv64(k, 64'(t));
    r = k - q * 64'(t);
    if (q[0]) begin
      r = 64'(t) - r;
    end
    s = quarter_sine(64'(t), r);
    mag = mul_q62(s, TTS_SINE_AMP);
    if (q >= 64'd2) begin
      return -$signed(mag[TTS_SINE_W-1:0]);
    end
    return $signed(mag[TTS_SINE_W-1:0]);
  endfunction

endpackage

`default_nettype wire

/* sv/tts_if.sv */
`default_nettype none

interface tts_in_if;
  import tts_pkg::*;
  logic valid;
  logic ready;
  logic [TTS_VOLUME_W-1:0] volume;

  modport source (output valid, output volume, input ready);
  modport sink (input valid, input volume, output ready);
endinterface

interface tts_out_if;
  import tts_pkg::*;
  logic valid;
  logic ready;
  logic [TTS_COMPARE_W-1:0] pwm_compare;

  modport source (output valid, output pwm_compare, input ready);
  modport sink (input valid, input pwm_compare, output ready);
endinterface

`default_nettype wire

/* sv/two_tone_wavetable_synth_core.sv */
// two-tone wavetable sample generator
// tick channel: one transaction per sample, carrying a 12-bit volume
// compare channel: one transaction per tick, the 13-bit pwm compare value
// apb port: increment_a at 0x0, increment_b at 0x4, midpoint_offset at 0x8,
//   writes in the access cycle, pready tied high, reads return the register
// writing zero to an increment also clears that tone's phase
// each accepted tick advances both phases, reads two sine entries with a
//   registered rom read, then mixes, scales and offsets into the output register
// a tick's result passes the rom stage register and then the output register,
//   where compare.valid rises; it is held there until compare.ready takes it
// throughput: one tick per cycle unless the compare channel stalls, set by the
//   combinational phase update and the registered rom read
// a stalled compare channel holds its result; one more tick is taken into
//   the rom stage if it is empty, then tick.ready drops until the result is taken
// reset (rst, synchronous): pipeline emptied, phases and increments zero,
//   midpoint_offset 1200; the sine rom is constant and needs no fill
`default_nettype none

module two_tone_wavetable_synth_core #(
  parameter int TABLE_SIZE = tts_pkg::TTS_TABLE_SIZE
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  tts_in_if.sink                                tick,
  tts_out_if.source                             compare,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [tts_pkg::TTS_PADDR_W-1:0]  paddr,
  input  wire logic [tts_pkg::TTS_PDATA_W-1:0]  pwdata,
  output logic      [tts_pkg::TTS_PDATA_W-1:0]  prdata,
  output logic                                  pready
);
  import tts_pkg::*;

  localparam int IdxW = $clog2(TABLE_SIZE);
  localparam int PhW = IdxW + TTS_FRAC_W;
  localparam int IntW = TTS_INC_W - TTS_FRAC_W;
  localparam logic [PhW:0] Limit = (PhW + 1)'(TABLE_SIZE) << TTS_FRAC_W;

  logic signed [TTS_SINE_W-1:0] sine_rom [TABLE_SIZE];

  for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_rom
    localparam logic signed [TTS_SINE_W-1:0] Entry = sine_entry(TABLE_SIZE, gi);
    assign sine_rom[gi] = Entry;
  end

  logic [TTS_INC_W-1:0] increment_a;
  logic [TTS_INC_W-1:0] increment_b;
  logic [TTS_OFS_W-1:0] midpoint_offset;
  logic [PhW-1:0] phase_a;
  logic [PhW-1:0] phase_b;
  logic [PhW-1:0] phase_a_next;
  logic [PhW-1:0] phase_b_next;

  logic s1_valid;
  logic signed [TTS_SINE_W-1:0] s1_sine_a;
  logic signed [TTS_SINE_W-1:0] s1_sine_b;
  logic [TTS_VOLUME_W-1:0] s1_volume;

  logic out_valid;
  logic [TTS_COMPARE_W-1:0] out_compare;
  logic [TTS_COMPARE_W-1:0] out_compare_next;

  logic cfg_write;
  logic accept;
  logic advance;

  // increment reduced modulo one table cycle
  function automatic logic [PhW-1:0] reduce_inc(logic [TTS_INC_W-1:0] inc);
    logic [IntW-1:0] v;
    v = inc[TTS_INC_W-1:TTS_FRAC_W];
    for (int k = IntW - 1; k >= 0; k--) begin
      if ((TABLE_SIZE << k) < (1 << IntW)) begin
        if (v >= IntW'(TABLE_SIZE << k)) begin
          v = v - IntW'(TABLE_SIZE << k);
        end
      end
    end
    return {IdxW'(v), inc[TTS_FRAC_W-1:0]};
  endfunction

  function automatic logic [PhW-1:0] step_phase(logic [PhW-1:0] ph, logic [TTS_INC_W-1:0] inc);
    logic [PhW:0] sum;
    sum = {1'b0, ph} + {1'b0, reduce_inc(inc)};
    if (sum >= Limit) begin
      sum = sum - Limit;
    end
    return sum[PhW-1:0];
  endfunction

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  assign advance = !out_valid || compare.ready;
  assign tick.ready = !s1_valid || advance;
  assign accept = tick.valid && tick.ready;

  assign phase_a_next = step_phase(phase_a, increment_a);
  assign phase_b_next = step_phase(phase_b, increment_b);

  always_comb begin
    unique case (paddr)
      TTS_ADDR_INC_A:  prdata = TTS_PDATA_W'(increment_a);
      TTS_ADDR_INC_B:  prdata = TTS_PDATA_W'(increment_b);
      TTS_ADDR_OFFSET: prdata = TTS_PDATA_W'(midpoint_offset);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      increment_a <= '0;
      increment_b <= '0;
      midpoint_offset <= TTS_OFFSET_RESET;
    end else if (cfg_write) begin
      unique case (paddr)
        TTS_ADDR_INC_A:  increment_a <= pwdata[TTS_INC_W-1:0];
        TTS_ADDR_INC_B:  increment_b <= pwdata[TTS_INC_W-1:0];
        TTS_ADDR_OFFSET: midpoint_offset <= pwdata[TTS_OFS_W-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_a <= '0;
    end else if (cfg_write && paddr == TTS_ADDR_INC_A && pwdata[TTS_INC_W-1:0] == '0) begin
      phase_a <= '0;
    end else if (accept) begin
      phase_a <= phase_a_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_b <= '0;
    end else if (cfg_write && paddr == TTS_ADDR_INC_B && pwdata[TTS_INC_W-1:0] == '0) begin
      phase_b <= '0;
    end else if (accept) begin
      phase_b <= phase_b_next;
    end
  end

  // rom stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sine_a <= sine_rom[phase_a_next[PhW-1:TTS_FRAC_W]];
      s1_sine_b <= sine_rom[phase_b_next[PhW-1:TTS_FRAC_W]];
      s1_volume <= tick.volume;
    end
  end

  // mix, scale, offset, clamp at zero
  always_comb begin
    logic signed [TTS_SINE_W:0] mix;
    logic signed [TTS_SINE_W+TTS_VOLUME_W+1:0] prod;
    logic signed [TTS_SINE_W+TTS_VOLUME_W+1-TTS_SAMPLE_SHIFT:0] scaled;
    logic signed [TTS_COMPARE_W:0] res;
    mix = (TTS_SINE_W + 1)'(s1_sine_a) + (TTS_SINE_W + 1)'(s1_sine_b);
    prod = mix * $signed({1'b0, s1_volume});
    scaled = prod[TTS_SINE_W+TTS_VOLUME_W+1:TTS_SAMPLE_SHIFT];
    res = (TTS_COMPARE_W + 1)'(scaled) + $signed({2'b00, midpoint_offset});
    out_compare_next = res[TTS_COMPARE_W] ? '0 : res[TTS_COMPARE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_compare <= out_compare_next;
    end
  end

  assign compare.valid = out_valid;
  assign compare.pwm_compare = out_compare;

`include "assert_macros.svh"

  `ASSERT_IMPL(a_phase_a_range, clk, rst, 1'b1, {1'b0, phase_a} < Limit, "phase_a out of range")
  `ASSERT_IMPL(a_phase_b_range, clk, rst, 1'b1, {1'b0, phase_b} < Limit, "phase_b out of range")
  `ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !advance, s1_valid, "rom stage lost a sample")
  `ASSERT_IMPL(a_full_stall, clk, rst, s1_valid && out_valid && !compare.ready, !tick.ready,
               "tick taken while pipeline full")
  `ASSERT_NEXT(a_zero_inc_clears, clk, rst,
               cfg_write && paddr == TTS_ADDR_INC_A && pwdata[TTS_INC_W-1:0] == '0,
               phase_a == '0, "zero increment did not clear phase_a")

endmodule

`default_nettype wire

/* bench/testbench.sv */
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tts_pkg::*;

  localparam int ROM_DEPTH = TTS_TABLE_SIZE;
  localparam logic [TTS_PADDR_W-1:0] ADDR_UNMAPPED = 4'hC;
  localparam logic [TTS_INC_W-1:0] INC_MAX = '1;
  localparam logic [TTS_OFS_W-1:0] OFS_MAX = '1;
  localparam logic [TTS_VOLUME_W-1:0] VOL_MAX = '1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 14;
  localparam int TICKS_PER_PHASE = 100;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [TTS_PADDR_W-1:0] paddr;
  logic [TTS_PDATA_W-1:0] pwdata;
  logic [TTS_PDATA_W-1:0] prdata;
  logic pready;

  tts_in_if tick_ch();
  tts_out_if compare_ch();

  two_tone_wavetable_synth_core uut (
    .clk(clk),
    .rst(rst),
    .tick(tick_ch),
    .compare(compare_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // model state
  logic [TTS_INC_W-1:0] model_inc_a;
  logic [TTS_INC_W-1:0] model_inc_b;
  logic [TTS_INC_W-1:0] model_phase_a;
  logic [TTS_INC_W-1:0] model_phase_b;
  logic [TTS_OFS_W-1:0] model_offset;
  logic signed [TTS_SINE_W-1:0] sine_rom [ROM_DEPTH];
  logic [TTS_COMPARE_W-1:0] compare_expected [$];

  logic tick_idle_en = 1'b1;
  logic ready_stall_en = 1'b1;
  logic ready_drive = 1'b1;
  int stall_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  assign compare_ch.ready = ready_drive;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [63:0] q62_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return 64'(p >> 62);
  endfunction

  function automatic logic [63:0] quarter_wave(int unsigned r);
    logic [63:0] span;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    int n;
    span = 64'(ROM_DEPTH);
    if (r == 0) return 64'd0;
    if (r >= ROM_DEPTH) return TTS_ONE_Q62;
    x = (TTS_HALF_PI_Q62 / span) * 64'(r) + ((TTS_HALF_PI_Q62 % span) * 64'(r)) / span;
    x2 = q62_product(x, x);
    term = x;
    acc = x;
    for (n = 1; n <= 12; n++) begin
      term = q62_product(term, x2) / (64'(2 * n) * 64'(2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  function automatic logic signed [TTS_SINE_W-1:0] rom_value(int unsigned i);
    int unsigned k;
    int unsigned quad;
    int unsigned r;
    int mag;
    k = 4 * i;
    quad = k / ROM_DEPTH;
    r = k % ROM_DEPTH;
    if (quad % 2 == 1) r = ROM_DEPTH - r;
    mag = int'(q62_product(quarter_wave(r), 64'd32767));
    return (quad >= 2) ? TTS_SINE_W'(-mag) : TTS_SINE_W'(mag);
  endfunction

  function automatic logic [TTS_INC_W-1:0] step_phase(logic [TTS_INC_W-1:0] phase,
                                                      logic [TTS_INC_W-1:0] inc);
    logic [63:0] span;
    logic [63:0] sum;
    span = 64'(ROM_DEPTH) << TTS_FRAC_W;
    sum = 64'(phase) + 64'(inc);
    if (sum >= span) sum = sum % span;
    return sum[TTS_INC_W-1:0];
  endfunction

  function automatic logic [TTS_COMPARE_W-1:0] predict_compare(logic [TTS_VOLUME_W-1:0] vol);
    int idx_a;
    int idx_b;
    longint mix;
    longint prod;
    longint level;
    model_phase_a = step_phase(model_phase_a, model_inc_a);
    model_phase_b = step_phase(model_phase_b, model_inc_b);
    idx_a = int'(model_phase_a >> TTS_FRAC_W) % ROM_DEPTH;
    idx_b = int'(model_phase_b >> TTS_FRAC_W) % ROM_DEPTH;
    mix = sine_rom[idx_a];
    mix = mix + sine_rom[idx_b];
    prod = mix * longint'(vol);
    level = (prod >>> TTS_SAMPLE_SHIFT) + longint'(model_offset);
    if (level < 0) level = 0;
    return level[TTS_COMPARE_W-1:0];
  endfunction

  function automatic void apply_register(logic [TTS_PADDR_W-1:0] addr,
                                         logic [TTS_PDATA_W-1:0] data);
    case (addr)
      TTS_ADDR_INC_A: begin
        model_inc_a = data[TTS_INC_W-1:0];
        if (model_inc_a == '0) model_phase_a = '0;
      end
      TTS_ADDR_INC_B: begin
        model_inc_b = data[TTS_INC_W-1:0];
        if (model_inc_b == '0) model_phase_b = '0;
      end
      TTS_ADDR_OFFSET: begin
        model_offset = data[TTS_OFS_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [TTS_PDATA_W-1:0] pick_increment();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return TTS_PDATA_W'(INC_MAX);
      2: return $urandom();
      3: return $urandom_range(1, 32'h10000);
      4: return TTS_PDATA_W'($urandom_range(1, 31)) << TTS_FRAC_W;
      default: return $urandom_range(0, 32'(INC_MAX));
    endcase
  endfunction

  task automatic wait_idle();
    tick_ch.valid <= 1'b0;
    while (compare_expected.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [TTS_PADDR_W-1:0] addr,
                                input logic [TTS_PDATA_W-1:0] data);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_register(addr, data);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_tick(input logic [TTS_VOLUME_W-1:0] vol);
    if (tick_idle_en && $urandom_range(0, 3) == 0) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.volume <= vol;
    do @(posedge clk); while (!tick_ch.ready);
    compare_expected.push_back(predict_compare(vol));
    @(negedge clk);
  endtask

  task automatic test_reset_values();
    send_tick('0);
    send_tick(VOL_MAX);
    send_tick(12'hAAA);
    send_tick(12'h555);
  endtask

  task automatic test_peak_mix();
    write_register(TTS_ADDR_INC_A, 32'(ROM_DEPTH / 4) << TTS_FRAC_W);
    write_register(TTS_ADDR_INC_B, 32'(ROM_DEPTH / 4) << TTS_FRAC_W);
    repeat (4) send_tick(VOL_MAX);
  endtask

  task automatic test_negative_saturation();
    write_register(TTS_ADDR_INC_A, 32'(3 * ROM_DEPTH / 4) << TTS_FRAC_W);
    write_register(TTS_ADDR_INC_B, 32'(3 * ROM_DEPTH / 4) << TTS_FRAC_W);
    write_register(TTS_ADDR_OFFSET, '0);
    send_tick(VOL_MAX);
    send_tick(12'd1);
    send_tick(VOL_MAX);
    send_tick(12'h800);
  endtask

  task automatic test_offset_max();
    write_register(TTS_ADDR_OFFSET, TTS_PDATA_W'(OFS_MAX));
    repeat (3) send_tick(VOL_MAX);
  endtask

  task automatic test_full_step_wrap();
    write_register(TTS_ADDR_INC_A, TTS_PDATA_W'(INC_MAX));
    write_register(TTS_ADDR_INC_B, TTS_PDATA_W'(INC_MAX));
    repeat (3) send_tick(TTS_VOLUME_W'($urandom()));
  endtask

  task automatic test_zero_clears_phase();
    // upper bits only, masks to zero
    write_register(TTS_ADDR_INC_A, 32'h0400_0000);
    repeat (2) send_tick(VOL_MAX);
    write_register(TTS_ADDR_INC_B, '0);
    send_tick(VOL_MAX);
    write_register(TTS_ADDR_INC_A, 32'hFFFF_FFFF);
    repeat (2) send_tick(VOL_MAX);
  endtask

  task automatic test_unmapped_register();
    write_register(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    repeat (2) send_tick(TTS_VOLUME_W'($urandom()));
  endtask

  task automatic test_random_traffic();
    logic [TTS_VOLUME_W-1:0] vol;
    logic [TTS_PDATA_W-1:0] ofs;
    int p;
    int n;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      tick_idle_en = (p < RANDOM_PHASES - 2) && (p % 4 != 3);
      ready_stall_en = tick_idle_en;
      case ($urandom_range(0, 4))
        0: ofs = '0;
        1: ofs = TTS_PDATA_W'(OFS_MAX);
        2: ofs = TTS_PDATA_W'(TTS_OFFSET_RESET);
        3: ofs = $urandom();
        default: ofs = $urandom_range(0, 32'(OFS_MAX));
      endcase
      write_register(TTS_ADDR_INC_A, pick_increment());
      write_register(TTS_ADDR_INC_B, pick_increment());
      write_register(TTS_ADDR_OFFSET, ofs);
      if ($urandom_range(0, 3) == 0) write_register(ADDR_UNMAPPED, $urandom());
      for (n = 0; n < TICKS_PER_PHASE; n++) begin
        case ($urandom_range(0, 9))
          0: vol = '0;
          1: vol = VOL_MAX;
          default: vol = TTS_VOLUME_W'($urandom_range(0, 32'(VOL_MAX)));
        endcase
        send_tick(vol);
      end
    end
  endtask

  // compare channel back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      ready_drive <= 1'b0;
    end else if (ready_stall_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 16);
      ready_drive <= 1'b0;
    end else begin
      ready_drive <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [TTS_COMPARE_W-1:0] want;
    if (!rst && compare_ch.valid && compare_ch.ready) begin
      if (compare_expected.size() == 0) begin
        $error("pwm_compare: transaction with none pending, actual %0d",
               compare_ch.pwm_compare);
        mismatches++;
      end else begin
        want = compare_expected.pop_front();
        if (compare_ch.pwm_compare !== want) begin
          $error("pwm_compare: expected %0d, actual %0d", want, compare_ch.pwm_compare);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    rst = 1'b1;
    tick_ch.valid = 1'b0;
    tick_ch.volume = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (k = 0; k < ROM_DEPTH; k++) sine_rom[k] = rom_value(k);
    model_inc_a = '0;
    model_inc_b = '0;
    model_phase_a = '0;
    model_phase_b = '0;
    model_offset = TTS_OFFSET_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_peak_mix();
    test_negative_saturation();
    test_offset_max();
    test_full_step_wrap();
    test_zero_clears_phase();
    test_unmapped_register();
    test_random_traffic();

    wait_idle();
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
